// ===== rtl/core/uvf_pkg.sv =====
package uvf_pkg;

  // Request codes carried in the op field.
  typedef enum logic {
    UVF_INSERT = 1'b0,
    UVF_REMOVE = 1'b1
  } uvf_op_e;

  // Result status codes.
  typedef enum logic [2:0] {
    UVF_OK    = 3'd0,
    UVF_NEG   = 3'd1,
    UVF_DUP   = 3'd2,
    UVF_FULL  = 3'd3,
    UVF_EMPTY = 3'd4
  } uvf_status_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    UVF_ST_IDLE,
    UVF_ST_EVAL,
    UVF_ST_SCAN,
    UVF_ST_POP,
    UVF_ST_RESP
  } uvf_state_e;

  localparam int unsigned ValueW = 32;
  localparam int unsigned EntryW = 31;

  localparam logic signed [ValueW-1:0] FailValue = '1;

  typedef struct packed {
    uvf_op_e                   op;
    logic signed [ValueW-1:0]  value;
  } uvf_in_t;

  typedef struct packed {
    logic signed [ValueW-1:0]  result_value;
    uvf_status_e               status;
  } uvf_out_t;

  // Finished result handed from the sequencer to the output register.
  typedef struct packed {
    logic      valid;
    uvf_out_t  beat;
  } uvf_res_t;

endpackage

// ===== rtl/core/unique_value_fifo_top.sv =====
// Unique value FIFO: a first-in first-out queue of non-negative 31-bit values
// that refuses duplicates. Each input beat on in_data_i is either an insert or
// a remove, and every input beat produces exactly one result beat on
// out_data_o with the value (or all ones on failure) and a status code.
// Both channels move a beat at a rising edge where valid is high and stall is
// low. Inserts are checked for a negative value, then for a duplicate, then
// for a full queue, and the first failing check sets the status.
// An insert scans the held values for a duplicate, reading the entry memory
// once per cycle through its single read port and comparing each word as it
// returns; a remove needs no scan. No new input beat is taken until the last
// result has moved into the output register; a result passes through the
// sequencer's result register and then the output register.
// Reset empties the queue (head and fill count cleared); the entry memory is
// not cleared, since only occupied slots are ever read.
// When the receiver stalls, the current result waits in the output register
// while the block takes one more input beat and holds its result internally
// until the register frees; in_stall_o stays high in the meantime.
module unique_value_fifo_top import uvf_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  uvf_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output uvf_out_t out_data_o
);

  uvf_res_t res;
  logic     res_take;
  logic     out_valid_q, out_valid_d;
  uvf_out_t out_data_q;

  uvf_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_beat_i  (in_data_i),
    .in_stall_o (in_stall_o),
    .res_o      (res),
    .res_take_i (res_take)
  );

  // The output register takes a new result when it is empty or being drained.
  assign res_take    = res.valid && (!out_valid_q || !out_stall_i);
  assign out_valid_d = res_take || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_data_q <= res.beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== rtl/core/uvf_ram.sv =====
module uvf_ram import uvf_pkg::*; #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/uvf_ctrl.sv =====
module uvf_ctrl import uvf_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  uvf_in_t  in_beat_i,
  output logic     in_stall_o,
  output uvf_res_t res_o,
  input  logic     res_take_i
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [AW:0]   DepthW = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LastSlot = AW'(DEPTH - 1);

  uvf_state_e state_q, state_d;
  uvf_in_t    beat_q, beat_d;
  uvf_out_t   res_q, res_d;
  logic [AW-1:0] head_q, head_d;
  logic [AW-1:0] rd_addr_q, rd_addr_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] k_q, k_d;

  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_raddr, tail;
  logic [AW:0]       tail_sum;
  logic [EntryW-1:0] rd_data;
  logic              hit, more, full, empty, neg;

  function automatic logic [AW-1:0] slot_next(input logic [AW-1:0] a);
    slot_next = (a == LastSlot) ? '0 : a + 1'b1;
  endfunction

  assign tail_sum = {1'b0, head_q} + {1'b0, count_q[AW-1:0]};
  assign tail     = (tail_sum >= DepthW) ? AW'(tail_sum - DepthW) : tail_sum[AW-1:0];
  assign hit      = (rd_data == beat_q.value[EntryW-1:0]);
  assign more     = (k_q < count_q);
  assign full     = (count_q == DepthC);
  assign empty    = (count_q == '0);
  assign neg      = beat_q.value[ValueW-1];

  uvf_ram #(.WIDTH(EntryW), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail),
    .wdata_i (beat_q.value[EntryW-1:0]),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rd_data)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      UVF_ST_IDLE: if (in_valid_i) state_d = UVF_ST_EVAL;
      UVF_ST_EVAL: begin
        if (beat_q.op == UVF_REMOVE) begin
          state_d = empty ? UVF_ST_RESP : UVF_ST_POP;
        end else if (neg || empty) begin
          state_d = UVF_ST_RESP;
        end else begin
          state_d = UVF_ST_SCAN;
        end
      end
      UVF_ST_SCAN: if (hit || !more) state_d = UVF_ST_RESP;
      UVF_ST_POP:  state_d = UVF_ST_RESP;
      UVF_ST_RESP: if (res_take_i) state_d = UVF_ST_IDLE;
      default:     state_d = UVF_ST_IDLE;
    endcase
  end

  always_comb begin
    beat_d    = beat_q;
    res_d     = res_q;
    head_d    = head_q;
    count_d   = count_q;
    k_d       = k_q;
    rd_addr_d = rd_addr_q;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = head_q;
    unique case (state_q)
      UVF_ST_IDLE: begin
        if (in_valid_i) beat_d = in_beat_i;
      end
      UVF_ST_EVAL: begin
        if (beat_q.op == UVF_REMOVE) begin
          if (empty) begin
            res_d = '{result_value: FailValue, status: UVF_EMPTY};
          end else begin
            ram_re = 1'b1;
          end
        end else if (neg) begin
          res_d = '{result_value: FailValue, status: UVF_NEG};
        end else if (empty) begin
          ram_we  = 1'b1;
          count_d = count_q + 1'b1;
          res_d   = '{result_value: beat_q.value, status: UVF_OK};
        end else begin
          ram_re    = 1'b1;
          rd_addr_d = slot_next(head_q);
          k_d       = CW'(1);
        end
      end
      UVF_ST_SCAN: begin
        // The word read last cycle is compared; the next read goes out meanwhile.
        if (hit) begin
          res_d = '{result_value: FailValue, status: UVF_DUP};
        end else if (more) begin
          ram_re    = 1'b1;
          ram_raddr = rd_addr_q;
          rd_addr_d = slot_next(rd_addr_q);
          k_d       = k_q + 1'b1;
        end else if (full) begin
          res_d = '{result_value: FailValue, status: UVF_FULL};
        end else begin
          ram_we  = 1'b1;
          count_d = count_q + 1'b1;
          res_d   = '{result_value: beat_q.value, status: UVF_OK};
        end
      end
      UVF_ST_POP: begin
        res_d   = '{result_value: {1'b0, rd_data}, status: UVF_OK};
        head_d  = slot_next(head_q);
        count_d = count_q - 1'b1;
      end
      UVF_ST_RESP: begin
      end
      default: begin
      end
    endcase
  end

  assign in_stall_o = (state_q != UVF_ST_IDLE);
  assign res_o.valid = (state_q == UVF_ST_RESP);
  assign res_o.beat  = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= UVF_ST_IDLE;
      head_q  <= '0;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q    <= beat_d;
    res_q     <= res_d;
    k_q       <= k_d;
    rd_addr_q <= rd_addr_d;
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= DepthC)
    else $error("fill count above depth");

  a_write_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (count_q < DepthC) && (beat_q.op == UVF_INSERT) && !neg)
    else $error("entry write with full queue or bad request");

  a_scan_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == UVF_ST_SCAN) |-> (k_q != '0) && (k_q <= count_q))
    else $error("scan index outside held entries");

  a_resp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_take_i) |=> res_o.valid && $stable(res_q)
                                     && $stable(count_q) && $stable(head_q))
    else $error("pending result or queue state changed");
`endif

endmodule
